/* hw/rtl/tga_rle_image_decoder_macros.svh */
// Assertion macros for the TGA RLE image decoder.
// Included by the top level; no other dependencies.
`ifndef TGA_RLE_IMAGE_DECODER_MACROS_SVH
`define TGA_RLE_IMAGE_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
`define TGA_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
`define TGA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TGA_ASSERT(name, clk, rst_n, prop, msg)
`define TGA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/tga_pkg.sv */
// Shared types and constants for the TGA RLE image decoder.
// No dependencies.
`default_nettype none

package tga_pkg;

    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_RUN       = 3'd1,
        KIND_CMAP_ERR  = 3'd2,
        KIND_TYPE_ERR  = 3'd3,
        KIND_DEPTH_ERR = 3'd4
    } kind_t;

    localparam logic [7:0] TYPE_RAW = 8'd2;
    localparam logic [7:0] TYPE_RLE = 8'd10;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    localparam logic [4:0] HIDX_ID_LEN    = 5'd0;
    localparam logic [4:0] HIDX_CMAP_TYPE = 5'd1;
    localparam logic [4:0] HIDX_IMG_TYPE  = 5'd2;
    localparam logic [4:0] HIDX_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HIDX_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HIDX_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HIDX_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HIDX_DEPTH     = 5'd16;
    localparam logic [4:0] HIDX_DESC      = 5'd17;

    // descriptor bit: set = top-left origin
    localparam int ORIGIN_TOP_BIT = 5;
    localparam int PKT_REPEAT_BIT = 7;

    localparam int TDATA_W = 112;
    localparam int TDATA_PAD = 6;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [1:0]  fmt;
        logic [15:0] row;
        logic [15:0] col;
        logic [7:0]  len;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        done;
    } rec_t;

    typedef struct packed {
        logic       start;
        logic       clear;
        logic [7:0] len;
    } div_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/tga_row_div.sv */
// Position tracker: advances file row/column by a run length.
// Divides (column + length) by the width, four quotient bits per cycle.
// Depends on tga_pkg.
`default_nettype none

module tga_row_div
    import tga_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire div_ctl_t    ctl,
    input  wire logic [15:0] width,
    output logic      [15:0] row,
    output logic      [15:0] col,
    output logic             busy
);

    logic [15:0] row_reg;
    logic [15:0] col_reg;
    logic        busy_reg;
    logic        half_reg;
    logic [16:0] rem_reg;
    logic [7:0]  quo_reg;
    logic [16:0] rem_next;
    logic [7:0]  quo_next;

    always_comb
    begin
        logic [23:0] rem_w;
        logic [23:0] dsh;
        logic [2:0]  k;
        rem_w    = {7'd0, rem_reg};
        quo_next = quo_reg;
        dsh      = '0;
        k        = '0;
        for (int i = 0; i < 4; i++)
        begin
            k   = {~half_reg, 2'(3 - i)};
            dsh = {8'd0, width} << k;
            if (rem_w >= dsh)
            begin
                rem_w       = rem_w - dsh;
                quo_next[k] = 1'b1;
            end
        end
        rem_next = rem_w[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            half_reg <= 1'b0;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else if (ctl.clear)
        begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            half_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            half_reg <= ~half_reg;
            if (half_reg)
            begin
                busy_reg <= 1'b0;
                row_reg  <= row_reg + {8'd0, quo_next};
                col_reg  <= rem_next[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= {1'b0, col_reg} + {9'd0, ctl.len};
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign row  = row_reg;
    assign col  = col_reg;
    assign busy = busy_reg;

endmodule

`default_nettype wire

/* hw/rtl/tga_parse.sv */
// Header parser and pixel/packet decoder: one file byte per step.
// Builds header, error and run records; drives the position tracker.
// Depends on tga_pkg.
`default_nettype none

module tga_parse
    import tga_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  data_byte,
    input  wire logic        sof,
    input  wire logic [15:0] row,
    input  wire logic [15:0] col,
    output logic             has_rec,
    output rec_t             rec,
    output div_ctl_t         div_ctl,
    output logic      [15:0] width
);

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_HEADER = 5'b00010,
        PH_IDSKIP = 5'b00100,
        PH_PKTHDR = 5'b01000,
        PH_PIXEL  = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [4:0]  hidx;
        logic [7:0]  id_skip;
        logic [7:0]  htype;
        logic [7:0]  flags;
        logic [15:0] width;
        logic [15:0] height;
        logic        alpha_mode;
        logic [7:0]  pkt_left;
        logic        repeats;
        logic [1:0]  chan;
        logic [31:0] colour;
        logic        cmap_nz;
        logic [7:0]  depth;
        logic [31:0] remaining;
    } pstate_t;

    localparam pstate_t ST_RESET = '{
        phase: PH_IDLE, hidx: '0, id_skip: '0, htype: '0, flags: '0,
        width: '0, height: '0, alpha_mode: 1'b0, pkt_left: '0,
        repeats: 1'b0, chan: '0, colour: '0, cmap_nz: 1'b0, depth: '0,
        remaining: '0
    };

    pstate_t     state_reg;
    pstate_t     state_next;
    logic [31:0] area_reg;

    always_comb
    begin
        pstate_t     cur;
        logic [7:0]  len;
        logic [31:0] colour_full;
        logic        last_chan;
        logic        done;
        logic        type_bad;
        logic        depth_bad;
        cur         = state_reg;
        len         = 8'd1;
        colour_full = '0;
        last_chan   = 1'b0;
        done        = 1'b0;
        type_bad    = 1'b0;
        depth_bad   = 1'b0;
        if (sof)
        begin
            cur       = ST_RESET;
            cur.phase = PH_HEADER;
        end
        state_next = cur;
        has_rec    = 1'b0;
        rec        = '0;
        div_ctl    = '0;

        case (cur.phase)
            PH_HEADER:
            begin
                state_next.hidx = cur.hidx + 5'd1;
                case (cur.hidx)
                    HIDX_ID_LEN:    state_next.id_skip = data_byte;
                    HIDX_CMAP_TYPE: state_next.cmap_nz = (data_byte != 8'd0);
                    HIDX_IMG_TYPE:  state_next.htype = data_byte;
                    HIDX_WIDTH_LO:  state_next.width[7:0] = data_byte;
                    HIDX_WIDTH_HI:  state_next.width[15:8] = data_byte;
                    HIDX_HEIGHT_LO: state_next.height[7:0] = data_byte;
                    HIDX_HEIGHT_HI: state_next.height[15:8] = data_byte;
                    HIDX_DEPTH:     state_next.depth = data_byte;
                    HIDX_DESC:
                    begin
                        state_next.flags = data_byte;
                        has_rec   = 1'b1;
                        type_bad  = (cur.htype != TYPE_RAW) && (cur.htype != TYPE_RLE);
                        depth_bad = (cur.depth != DEPTH_24) && (cur.depth != DEPTH_32);
                        if (cur.cmap_nz || type_bad || depth_bad)
                        begin
                            rec.kind = cur.cmap_nz ? KIND_CMAP_ERR
                                     : (type_bad ? KIND_TYPE_ERR : KIND_DEPTH_ERR);
                            rec.done = 1'b1;
                            state_next.phase = PH_IDLE;
                        end
                        else
                        begin
                            state_next.alpha_mode = (cur.depth == DEPTH_32);
                            state_next.remaining  = area_reg;
                            div_ctl.clear = 1'b1;
                            rec.kind   = KIND_HEADER;
                            rec.width  = cur.width;
                            rec.height = cur.height;
                            rec.fmt    = {~data_byte[ORIGIN_TOP_BIT], cur.depth == DEPTH_32};
                            if (cur.width == 16'd0 || cur.height == 16'd0)
                            begin
                                rec.done = 1'b1;
                                state_next.phase = PH_IDLE;
                            end
                            else if (cur.id_skip != 8'd0)
                            begin
                                state_next.phase = PH_IDSKIP;
                            end
                            else
                            begin
                                state_next.chan     = '0;
                                state_next.colour   = '0;
                                state_next.pkt_left = '0;
                                state_next.repeats  = 1'b0;
                                state_next.phase    = (cur.htype == TYPE_RLE) ? PH_PKTHDR
                                                                             : PH_PIXEL;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            PH_IDSKIP:
            begin
                state_next.id_skip = cur.id_skip - 8'd1;
                if (state_next.id_skip == 8'd0)
                begin
                    state_next.chan     = '0;
                    state_next.colour   = '0;
                    state_next.pkt_left = '0;
                    state_next.repeats  = 1'b0;
                    state_next.phase    = (cur.htype == TYPE_RLE) ? PH_PKTHDR : PH_PIXEL;
                end
            end

            PH_PKTHDR:
            begin
                state_next.repeats  = data_byte[PKT_REPEAT_BIT];
                state_next.pkt_left = {1'b0, data_byte[6:0]} + 8'd1;
                state_next.chan     = '0;
                state_next.colour   = '0;
                state_next.phase    = PH_PIXEL;
            end

            PH_PIXEL:
            begin
                colour_full = cur.colour;
                colour_full[{cur.chan, 3'b000} +: 8] = data_byte;
                state_next.colour = colour_full;
                state_next.chan   = cur.chan + 2'd1;
                last_chan = cur.alpha_mode ? (cur.chan == 2'd3) : (cur.chan == 2'd2);
                if (last_chan)
                begin
                    if (cur.repeats)
                    begin
                        // repeat run clipped at the image end
                        len = ({24'd0, cur.pkt_left} > cur.remaining) ? cur.remaining[7:0]
                                                                     : cur.pkt_left;
                        state_next.pkt_left = '0;
                    end
                    else if (cur.pkt_left != 8'd0)
                    begin
                        state_next.pkt_left = cur.pkt_left - 8'd1;
                    end
                    done = (cur.remaining == {24'd0, len});
                    state_next.remaining = cur.remaining - {24'd0, len};

                    has_rec   = 1'b1;
                    rec.kind  = KIND_RUN;
                    rec.fmt   = {~cur.flags[ORIGIN_TOP_BIT], cur.alpha_mode};
                    rec.row   = cur.flags[ORIGIN_TOP_BIT] ? row : (cur.height - 16'd1 - row);
                    rec.col   = col;
                    rec.len   = len;
                    rec.red   = colour_full[23:16];
                    rec.green = colour_full[15:8];
                    rec.blue  = colour_full[7:0];
                    rec.alpha = cur.alpha_mode ? colour_full[31:24] : 8'd0;
                    rec.done  = done;

                    div_ctl.start = 1'b1;
                    div_ctl.len   = len;

                    state_next.chan   = '0;
                    state_next.colour = '0;
                    if (done)
                        state_next.phase = PH_IDLE;
                    else if (cur.htype == TYPE_RLE && state_next.pkt_left == 8'd0)
                        state_next.phase = PH_PKTHDR;
                end
            end

            default: ;
        endcase

        if (!step)
        begin
            has_rec = 1'b0;
            div_ctl = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_RESET;
        else if (step)
            state_reg <= state_next;
    end

    // pixel count of the image, registered from the stored width and height
    always_ff @(posedge clk)
    begin
        area_reg <= {16'd0, state_reg.width} * {16'd0, state_reg.height};
    end

    assign width = state_reg.width;

endmodule

`default_nettype wire

/* hw/rtl/tga_out_reg.sv */
// Output record register with stream handshake.
// Depends on tga_pkg.
`default_nettype none

module tga_out_reg
    import tga_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  wire rec_t rec_in,
    input  wire logic ready,
    output logic      valid,
    output logic      space,
    output rec_t      rec_out
);

    logic valid_reg;
    rec_t rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rec_reg <= rec_in;
    end

    assign valid   = valid_reg;
    assign space   = !valid_reg || ready;
    assign rec_out = rec_reg;

endmodule

`default_nettype wire

/* hw/rtl/tga_rle_image_decoder.sv */
// TGA RLE image decoder top level: input register, parser, position tracker,
// output register. Depends on tga_pkg, tga_parse, tga_row_div, tga_out_reg
// and tga_rle_image_decoder_macros.svh.
//
// Usage:
//   Slave stream: one file byte per request in s_axis_tdata; s_axis_tuser set
//   on the first header byte restarts parsing. Bytes arriving before a start,
//   after an error or after the image end are dropped.
//   Master stream: zero or one record per byte. tuser holds the record kind,
//   tlast marks the record that completes the image or reports an error.
//   Records: a byte passes from the input register through the parse step into
//   the output register. Throughput: one byte per cycle while the receiver does
//   not stall, set by the combinational parse step between the two registers.
//   Run positions are advanced by a registered divider, hidden behind the three
//   or four colour bytes of the next pixel.
//   Reset: the decoder is idle and waits for a start byte.
//   Stall: while the receiver holds tready low the output record holds,
//   one more byte is buffered, then s_axis_tready drops.
`default_nettype none

module tga_rle_image_decoder
    import tga_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // data_byte
    input  wire logic               s_axis_tuser,   // start_of_file
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // image_width, image_height, pixel_format, start_row, start_column,
    // run_length, red, green, blue, alpha, zero pad
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic [2:0]              m_axis_tuser,   // record_kind
    output logic                    m_axis_tlast    // image_done
);

`include "tga_rle_image_decoder_macros.svh"

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_sof_reg;
    logic        step;
    logic        out_space;
    logic        has_rec;
    logic        load;
    rec_t        rec;
    rec_t        rec_out;
    div_ctl_t    div_ctl;
    logic [15:0] width;
    logic [15:0] row;
    logic [15:0] col;
    logic        div_busy;

    assign step          = in_valid_reg && out_space;
    assign s_axis_tready = !in_valid_reg || step;
    assign load          = step && has_rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            in_valid_reg <= 1'b1;
        else if (step)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_sof_reg  <= s_axis_tuser;
        end
    end

    tga_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .sof       (in_sof_reg),
        .row       (row),
        .col       (col),
        .has_rec   (has_rec),
        .rec       (rec),
        .div_ctl   (div_ctl),
        .width     (width)
    );

    tga_row_div u_row_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .width (width),
        .row   (row),
        .col   (col),
        .busy  (div_busy)
    );

    tga_out_reg u_out_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .rec_in  (rec),
        .ready   (m_axis_tready),
        .valid   (m_axis_tvalid),
        .space   (out_space),
        .rec_out (rec_out)
    );

    assign m_axis_tdata = {TDATA_PAD'(0), rec_out.alpha, rec_out.blue, rec_out.green,
                           rec_out.red, rec_out.len, rec_out.col, rec_out.row,
                           rec_out.fmt, rec_out.height, rec_out.width};
    assign m_axis_tuser = rec_out.kind;
    assign m_axis_tlast = rec_out.done;

    `TGA_ASSERT(a_div_free_at_run, clk, rst_n, !(div_ctl.start && div_busy), "run position used while divider busy")
    `TGA_ASSERT(a_start_clear_excl, clk, rst_n, !(div_ctl.start && div_ctl.clear), "divider start and clear together")
    `TGA_ASSERT_NEXT(a_div_busy_after, clk, rst_n, div_ctl.start, div_busy, "divider not busy after start")
    `TGA_ASSERT(a_run_len_nonzero, clk, rst_n, !(m_axis_tvalid && rec_out.kind == KIND_RUN) || rec_out.len != 8'd0, "run record with zero length")

endmodule

`default_nettype wire
